### design/hist_pkg.sv
// package for the histogram block: sizes, command and result codes, sequencer states
`default_nettype none
package hist_pkg;

	localparam int NUM_BINS = 128;
	localparam int BIN_W    = $clog2(NUM_BINS);
	localparam int CNT_W    = 32;
	localparam int MASK_W   = 64;
	localparam int RANK_W   = 2;
	localparam int IN_W     = 8;
	localparam int OUT_W    = 112;

	typedef logic [BIN_W-1:0] bin_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_MASK   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_TOP     = 2'd1,
		KIND_MASK    = 2'd2,
		KIND_CLEARED = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

### design/histogram_top3_missing.sv
// histogram with top three report and missing-bin map, one shared compare unit
//
// input channel s_*: tuser carries the command (sample, report, mask chunk, clear),
// tdata the sample value and its negative flag. results leave on m_*: tuser is
// the result kind, tlast marks the final result of one input transfer.
// cfg_we/cfg_wdata set max_value, the largest bin counted.
// one input transfer is taken at a time; s_tready is high only while idle.
// a sample reads its bin and writes it back before its result; an out-of-range
// sample skips the write. a clear goes straight to its result. a mask chunk scans
// bins 0..max_value one per cycle through the count memory. a report runs that
// scan once per entry with a single 32-bit compare, skipping bins already
// reported, for up to three entries.
// results go through one output register; a stalled receiver holds the block
// in its emit step until the register is free, and no input is taken then.
// reset clears all counts at once through per-bin valid flags, max_value
// returns to 100 and both channels go empty.
`default_nettype none
module histogram_top3_missing (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [6:0]                  cfg_wdata,
	input  wire                        s_tvalid,
	output logic                       s_tready,
	input  wire [hist_pkg::IN_W-1:0]   s_tdata,   // value[6:0], sample_negative[7]
	input  wire [1:0]                  s_tuser,   // command
	output logic                       m_tvalid,
	input  wire                        m_tready,
	output logic [hist_pkg::OUT_W-1:0] m_tdata,   // out_of_range[0], rank[2:1], bin_value[9:3],
	                                              // bin_count[41:10], missing_mask[105:42],
	                                              // all_present[106], zero pad
	output logic [1:0]                 m_tuser,   // kind
	output logic                       m_tlast
);
	import hist_pkg::*;

	state_t state_q, state_d;

	logic [6:0]        max_value_q;
	cmd_t              cmd_q;
	bin_t              val_q;
	logic              oor_q;
	bin_t              scan_q;
	logic [RANK_W-1:0] rank_q;
	bin_t              taken_q [2];
	logic              have_q;
	bin_t              best_idx_q;
	cnt_t              best_cnt_q;
	logic [MASK_W-1:0] mask_q;
	logic              allp_q;

	cnt_t              mem [NUM_BINS];
	logic [NUM_BINS-1:0] valid_q;
	cnt_t              rdata_q;
	logic              rvld_q;
	logic              p_s1;
	bin_t              idx_s1;

	logic              m_tvalid_q;
	logic              accept;
	logic              emit;
	logic              slot_free;
	bin_t              raddr;
	bin_t              top;
	logic [RANK_W-1:0] last_rank;
	logic              is_last;
	cnt_t              cnt_eff;
	logic              eligible;
	logic              better;
	logic              in_oor;
	cmd_t              in_cmd;
	logic [OUT_W-1:0]  tdata_d;

	assign top       = max_value_q;
	assign last_rank = (top < bin_t'(2)) ? top[RANK_W-1:0] : RANK_W'(2);
	assign in_cmd    = cmd_t'(s_tuser);
	assign in_oor    = s_tdata[7] || (s_tdata[6:0] > top);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign cnt_eff   = rvld_q ? rdata_q : '0;
	assign is_last   = (cmd_q != CMD_REPORT) || (rank_q == last_rank);
	assign eligible  = !((rank_q >= RANK_W'(1)) && (idx_s1 == taken_q[0])) &&
	                   !((rank_q >= RANK_W'(2)) && (idx_s1 == taken_q[1]));
	assign better    = !have_q || (cnt_eff > best_cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (in_cmd)
						CMD_SAMPLE: state_d = in_oor ? ST_EMIT : ST_INC;
						CMD_REPORT: state_d = ST_SCAN;
						CMD_MASK:   state_d = ST_SCAN;
						CMD_CLEAR:  state_d = ST_EMIT;
						default:    state_d = ST_EMIT;
					endcase
				end
			end
			ST_INC:   state_d = ST_EMIT;
			ST_SCAN:  state_d = (scan_q == top) ? ST_DRAIN : ST_SCAN;
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (slot_free)
					state_d = is_last ? ST_IDLE : ST_SCAN;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		emit     = 1'b0;
		raddr    = scan_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				raddr    = s_tdata[6:0];
			end
			ST_EMIT:  emit = slot_free;
			default:  ;
		endcase
	end

	// result word
	always_comb begin
		tdata_d = '0;
		case (cmd_q)
			CMD_SAMPLE: tdata_d[0] = oor_q;
			CMD_REPORT: begin
				tdata_d[2:1]   = rank_q;
				tdata_d[9:3]   = best_idx_q;
				tdata_d[41:10] = best_cnt_q;
			end
			CMD_MASK: begin
				tdata_d[105:42] = mask_q;
				tdata_d[106]    = allp_q;
			end
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			max_value_q <= 7'd100;
			valid_q     <= '0;
			m_tvalid_q  <= 1'b0;
			p_s1        <= 1'b0;
			rank_q      <= '0;
			have_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			p_s1    <= (state_q == ST_SCAN);
			if (cfg_we)
				max_value_q <= cfg_wdata;
			if (accept && in_cmd == CMD_CLEAR)
				valid_q <= '0;
			if (state_q == ST_INC)
				valid_q[val_q] <= 1'b1;
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			if (accept)
				rank_q <= '0;
			else if (emit && !is_last)
				rank_q <= rank_q + RANK_W'(1);
			if (accept || emit)
				have_q <= 1'b0;
			else if (p_s1 && eligible && better)
				have_q <= 1'b1;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (state_q == ST_INC)
			mem[val_q] <= (cnt_eff == '1) ? cnt_eff : cnt_eff + cnt_t'(1);
		rdata_q <= mem[raddr];
		rvld_q  <= valid_q[raddr];
	end

	// datapath
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (accept) begin
			cmd_q <= in_cmd;
			val_q <= s_tdata[6:0];
			oor_q <= (in_cmd == CMD_SAMPLE) && in_oor;
		end
		if (accept || emit) begin
			scan_q <= '0;
			mask_q <= '0;
			allp_q <= 1'b1;
		end else if (state_q == ST_SCAN) begin
			scan_q <= scan_q + bin_t'(1);
		end
		if (p_s1) begin
			if (eligible && better) begin
				best_idx_q <= idx_s1;
				best_cnt_q <= cnt_eff;
			end
			if (cnt_eff == '0) begin
				allp_q <= 1'b0;
				if (val_q[6:1] == 6'd0 && idx_s1[6] == val_q[0])
					mask_q[idx_s1[5:0]] <= 1'b1;
			end
		end
		if (emit && cmd_q == CMD_REPORT && rank_q < RANK_W'(2))
			taken_q[rank_q[0]] <= best_idx_q;
		if (emit) begin
			m_tdata <= tdata_d;
			m_tlast <= is_last;
			case (cmd_q)
				CMD_SAMPLE: m_tuser <= KIND_ACK;
				CMD_REPORT: m_tuser <= KIND_TOP;
				CMD_MASK:   m_tuser <= KIND_MASK;
				CMD_CLEAR:  m_tuser <= KIND_CLEARED;
				default:    m_tuser <= KIND_CLEARED;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule
`default_nettype wire

### sim/hist_checker.sv
// checker for the histogram block: follows every transfer, predicts the results and compares them
module hist_checker (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [6:0]                  cfg_wdata,
	input  wire                        s_tvalid,
	input  wire                        s_tready,
	input  wire [hist_pkg::IN_W-1:0]   s_tdata,   // value[6:0], sample_negative[7]
	input  wire [1:0]                  s_tuser,   // command
	input  wire                        m_tvalid,
	input  wire                        m_tready,
	input  wire [hist_pkg::OUT_W-1:0]  m_tdata,   // out_of_range, rank, bin_value, bin_count,
	                                              // missing_mask, all_present, zero pad
	input  wire [1:0]                  m_tuser,   // kind
	input  wire                        m_tlast,
	output int                         mismatches,
	output int                         outstanding
);
	import hist_pkg::*;

	localparam int MAX_VALUE_RESET = 100;
	localparam int REPORT_LEN      = 3;

	typedef struct packed {
		kind_t              kind;
		logic               out_of_range;
		logic [RANK_W-1:0]  rank;
		bin_t               bin_value;
		cnt_t               bin_count;
		logic [MASK_W-1:0]  missing_mask;
		logic               all_present;
		logic               last;
	} hist_result_t;

	cnt_t         bin_tally [NUM_BINS];
	logic [6:0]   max_value;
	hist_result_t awaited_results [$];

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	task automatic tally_item(cmd_t cmd, logic [6:0] value, logic negative);
		hist_result_t res;
		bit           taken [NUM_BINS];
		int           top;
		int           n;
		int           best;
		int           b;
		top = (int'(max_value) > NUM_BINS - 1) ? NUM_BINS - 1 : int'(max_value);
		res = '0;
		res.last = 1'b1;
		case (cmd)
		CMD_SAMPLE: begin
			res.kind = KIND_ACK;
			res.out_of_range = negative || (value > top);
			if (!res.out_of_range && bin_tally[value] != '1)
				bin_tally[value] = bin_tally[value] + cnt_t'(1);
			awaited_results.push_back(res);
		end
		CMD_REPORT: begin
			n = (top + 1 < REPORT_LEN) ? top + 1 : REPORT_LEN;
			foreach (taken[i])
				taken[i] = 1'b0;
			// repeated max search, strict compare keeps the lower bin on ties
			for (int k = 0; k < n; k++) begin
				best = -1;
				for (int i = 0; i <= top; i++)
					if (!taken[i] && (best < 0 || bin_tally[i] > bin_tally[best]))
						best = i;
				taken[best] = 1'b1;
				res.kind = KIND_TOP;
				res.rank = RANK_W'(k);
				res.bin_value = bin_t'(best);
				res.bin_count = bin_tally[best];
				res.last = (k == n - 1);
				awaited_results.push_back(res);
			end
		end
		CMD_MASK: begin
			res.kind = KIND_MASK;
			res.all_present = 1'b1;
			for (int i = 0; i <= top; i++)
				if (bin_tally[i] == '0)
					res.all_present = 1'b0;
			for (int i = 0; i < MASK_W; i++) begin
				b = value * MASK_W + i;
				if (b <= top && bin_tally[b] == '0)
					res.missing_mask[i] = 1'b1;
			end
			awaited_results.push_back(res);
		end
		CMD_CLEAR: begin
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			res.kind = KIND_CLEARED;
			awaited_results.push_back(res);
		end
		endcase
	endtask

	task automatic check_result;
		hist_result_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected transfer, expected none, actual kind %0d data %h",
				$time, m_tuser, m_tdata);
			mismatches++;
		end else begin
			want = awaited_results.pop_front();
			compare_field("kind", 64'(want.kind), 64'(m_tuser));
			compare_field("out_of_range", 64'(want.out_of_range), 64'(m_tdata[0]));
			compare_field("rank", 64'(want.rank), 64'(m_tdata[2:1]));
			compare_field("bin_value", 64'(want.bin_value), 64'(m_tdata[9:3]));
			compare_field("bin_count", 64'(want.bin_count), 64'(m_tdata[41:10]));
			compare_field("missing_mask", want.missing_mask, m_tdata[105:42]);
			compare_field("all_present", 64'(want.all_present), 64'(m_tdata[106]));
			compare_field("last", 64'(want.last), 64'(m_tlast));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			max_value = 7'(MAX_VALUE_RESET);
			awaited_results.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				tally_item(cmd_t'(s_tuser), s_tdata[6:0], s_tdata[7]);
			if (cfg_we)
				max_value = cfg_wdata;
		end
		outstanding <= awaited_results.size();
	end

endmodule

### sim/tb.sv
// testbench top for the histogram block: stimulus, receiver stalls and the verdict
module tb;
	import hist_pkg::*;

	localparam int PHASES     = 10;
	localparam int PHASE_LEN  = 48;
	localparam int LONG_HOLD  = 250;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [6:0]          cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata   = '0;
	logic [1:0]          s_tuser   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	int                  mismatches;
	int                  outstanding;
	int                  stall_pct = 0;
	int                  cur_max   = 100;
	bit                  hold_off  = 1'b0;

	histogram_top3_missing dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	hist_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send(cmd_t cmd, logic [6:0] value, logic negative);
		int gap;
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {negative, value};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic settle;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max(int value);
		cfg_we    <= 1'b1;
		cfg_wdata <= 7'(value);
		cur_max = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver side: random stall bursts plus one long hold-off
	initial begin : sink
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off = 1'b0;
				m_tready <= 1'b1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				gap = $urandom_range(1, 8);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int          plan [PHASES];
		int          pick;
		int          r;
		logic [6:0]  v;
		logic        neg;
		plan = '{127, 0, 1, 100, 2, 63, 64, 5, 0, 127};
		plan[7] = $urandom_range(3, 126);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, first with max_value at its reset value, then at 0, 1 and 127
		stall_pct = 20;
		send(CMD_REPORT, 7'd0, 1'b0);
		send(CMD_MASK, 7'd0, 1'b0);
		send(CMD_MASK, 7'd1, 1'b0);
		send(CMD_MASK, 7'd127, 1'b0);
		send(CMD_SAMPLE, 7'd0, 1'b0);
		send(CMD_SAMPLE, 7'd100, 1'b0);
		send(CMD_SAMPLE, 7'd100, 1'b0);
		send(CMD_SAMPLE, 7'd101, 1'b0);
		send(CMD_SAMPLE, 7'd127, 1'b0);
		send(CMD_SAMPLE, 7'd5, 1'b1);
		send(CMD_SAMPLE, 7'd0, 1'b1);
		send(CMD_REPORT, 7'd127, 1'b1);
		send(CMD_MASK, 7'd1, 1'b1);
		send(CMD_CLEAR, 7'd127, 1'b1);
		send(CMD_REPORT, 7'd0, 1'b0);
		settle();
		write_max(0);
		send(CMD_SAMPLE, 7'd0, 1'b0);
		send(CMD_SAMPLE, 7'd1, 1'b0);
		send(CMD_REPORT, 7'd0, 1'b0);
		send(CMD_MASK, 7'd0, 1'b0);
		settle();
		write_max(1);
		send(CMD_SAMPLE, 7'd1, 1'b0);
		send(CMD_REPORT, 7'd0, 1'b0);
		send(CMD_MASK, 7'd0, 1'b0);
		settle();
		write_max(127);
		send(CMD_SAMPLE, 7'd127, 1'b0);
		send(CMD_MASK, 7'd1, 1'b0);

		// random part, one max_value setting per phase
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_max(plan[p]);
			if (p == PHASES - 1)
				stall_pct = 0;
			else if (p == 0)
				stall_pct = 30;
			else
				stall_pct = $urandom_range(0, 2) * 20;
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (p == 2 && i == 10)
					hold_off = 1'b1;
				r    = $urandom_range(0, 99);
				pick = $urandom_range(0, 9);
				neg  = ($urandom_range(0, 15) == 0);
				if (r < 66) begin
					if (pick < 2)
						v = 7'($urandom_range(0, 127));
					else if (pick < 6 && cur_max > 7)
						v = 7'($urandom_range(0, 7));
					else
						v = 7'($urandom_range(0, cur_max));
					send(CMD_SAMPLE, v, neg);
				end else if (r < 80) begin
					send(CMD_REPORT, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				end else if (r < 96) begin
					v = (pick == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 1));
					send(CMD_MASK, v, 1'($urandom_range(0, 1)));
				end else begin
					send(CMD_CLEAR, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
				end
			end
		end
		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#10000000;
		$display("Verification failed");
		$finish;
	end

endmodule
